>>> sv/osir_pkg.sv
// Shared types and codes for the ordered set insert/remove core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package osir_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_PRESENT = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_FULL    = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // Operation codes carried in req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;        // capture the incoming transaction
      logic       rd_en;       // read the store
      logic       rd_next;     // read at index + 1 instead of index
      logic       wr_en;       // write the store at index
      logic       wr_from_rd;  // write data is the last read word, else the operand
      logic       idx_inc;     // advance the index
      logic       occ_inc;     // one more entry held
      logic       occ_dec;     // one entry fewer held
      logic       rsp_load;    // load the result register
      status_type status;      // status for the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic req_mode;   // operation of the transaction being offered
      logic is_remove;  // operation of the captured transaction
      logic full;       // store holds every slot
      logic empty;      // store holds nothing
      logic at_end;     // index has reached the occupancy
      logic next_end;   // index + 1 has reached the occupancy
      logic match;      // last read word equals the operand
      logic rsp_free;   // result register can take a new result
   } sts_type;

endpackage

`default_nettype wire

>>> sv/osir_ctrl.sv
// Sequencer for the ordered set: scan, append and compaction steps.
// Depends on osir_pkg for command, status and code types.
`default_nettype none

module osir_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire osir_pkg::sts_type sts,
   output osir_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_CMP   = 6'b000100,
      S_SHIFT = 6'b001000,
      S_MOVE  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   osir_pkg::status_type status_ff, status_in;

   // Next state and command decode
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.status = status_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (sts.req_mode == osir_pkg::OP_INSERT && sts.full) begin
                  status_in = osir_pkg::ST_FULL;
                  state_in  = S_RESP;
               end else if (sts.req_mode == osir_pkg::OP_REMOVE && sts.empty) begin
                  status_in = osir_pkg::ST_EMPTY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.at_end) begin
               // value not held: append on insert
               if (!sts.is_remove) begin
                  cmd.wr_en   = 1'b1;
                  cmd.occ_inc = 1'b1;
                  status_in   = osir_pkg::ST_DONE;
               end else begin
                  status_in = osir_pkg::ST_ABSENT;
               end
               state_in = S_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               if (!sts.is_remove) begin
                  status_in = osir_pkg::ST_PRESENT;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SHIFT;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SHIFT: begin
            if (sts.next_end) begin
               cmd.occ_dec = 1'b1;
               status_in   = osir_pkg::ST_DONE;
               state_in    = S_RESP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_MOVE;
            end
         end
         S_MOVE: begin
            // move the later entry down one place
            cmd.wr_en      = 1'b1;
            cmd.wr_from_rd = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = S_SHIFT;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= osir_pkg::ST_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/osir_dp.sv
// Datapath for the ordered set: entry memory, index, occupancy, result register.
// Depends on osir_pkg for command and status types.
`default_nettype none

module osir_dp #(
   parameter int DEPTH = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_mode,
   input  wire logic [31:0]       req_value,
   input  wire osir_pkg::cmd_type cmd,
   output osir_pkg::sts_type      sts,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [31:0]   value_ff;
   logic          mode_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] idx_plus;
   logic [CW-1:0] rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [7:0]    rsp_count_ff;

   assign idx_plus = idx_ff + CW'(1);
   assign rd_addr  = cmd.rd_next ? idx_plus : idx_ff;

   // Entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[AW-1:0]] <= cmd.wr_from_rd ? rd_data_ff : value_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   // Capture operand
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
   end

   // Index and occupancy
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
      occ_in = occ_ff;
      if (cmd.occ_inc) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         occ_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         occ_ff <= occ_in;
      end
   end

   // Result register: hold until taken
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.status;
         rsp_count_ff  <= 8'(occ_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // Status to the controller
   always_comb begin
      sts.req_mode  = req_mode;
      sts.is_remove = (mode_ff == osir_pkg::OP_REMOVE);
      sts.full      = (occ_ff == CW'(DEPTH));
      sts.empty     = (occ_ff == '0);
      sts.at_end    = (idx_ff == occ_ff);
      sts.next_end  = (idx_plus == occ_ff);
      sts.match     = (rd_data_ff == value_ff);
      sts.rsp_free  = ~rsp_valid_ff | rsp_tready;
   end

endmodule

`default_nettype wire

>>> sv/ordered_set_insert_remove_core.sv
// Ordered set of 32-bit values, insert or remove one value per transaction.
// An accepted request scans the entries in order, one read and compare per entry; an insert that
// finds no match appends at the end, and a remove moves each later entry down one place.
// Full/empty rejects go straight to the result. One transaction at a time: the next is accepted
// in the cycle after the result is loaded; the entry memory has one write and one read port.
// Reset clears occupancy and control; entries are not cleared and are read only below count.
`default_nettype none

module ordered_set_insert_remove_core #(
   parameter int DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [2:0] status, [10:3] count, [15:11] zero
);

   osir_pkg::cmd_type cmd;
   osir_pkg::sts_type sts;
   logic [2:0]        rsp_status;
   logic [7:0]        rsp_count;

   osir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   osir_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {5'b0, rsp_count, rsp_status};

   // One transaction in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a transaction while one is in progress");

   // No store write while waiting for input
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.wr_en)
      else $error("entry write while idle");

   // Never grow past capacity
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.occ_inc |-> !sts.full)
      else $error("append into a full store");

   // Never shrink below zero
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.occ_dec |-> !sts.empty)
      else $error("remove from an empty store");

endmodule

`default_nettype wire

>>> test/ordered_set_insert_remove_checker.sv
// Scoreboard for the ordered set core: tracks the set contents from the request
// channel, predicts status and count, and compares each response transaction.
// Depends on osir_pkg for the operation and status codes.
`timescale 1ns / 1ps

module ordered_set_insert_remove_checker #(
   parameter int DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] mode
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [2:0] status, [10:3] count, [15:11] zero
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               peak,
   output logic [4:0]       status_seen
);

   typedef struct packed {
      osir_pkg::status_type status;
      logic [7:0]           count;
   } outcome_type;

   // Shadow copy of the set, in insertion order
   logic [31:0]          held [DEPTH];
   int                   occupancy;
   outcome_type          outcome_q [$];

   int                   fails;
   int                   results;
   int                   top_count;
   logic [4:0]           seen;
   outcome_type          want;
   osir_pkg::status_type got_status;
   logic [7:0]           got_count;
   osir_pkg::status_type next_status;

   // Apply one insert or remove to the shadow set and return its status
   function automatic osir_pkg::status_type apply_set_op(input logic op,
                                                         input logic [31:0] value);
      int slot;
      slot = occupancy;
      for (int i = occupancy - 1; i >= 0; i--) begin
         if (held[i] == value) slot = i;
      end
      if (op == osir_pkg::OP_INSERT) begin
         // full test comes first, even when the value is already held
         if (occupancy >= DEPTH) return osir_pkg::ST_FULL;
         if (slot < occupancy) return osir_pkg::ST_PRESENT;
         held[occupancy] = value;
         occupancy++;
         return osir_pkg::ST_DONE;
      end
      if (occupancy == 0) return osir_pkg::ST_EMPTY;
      if (slot >= occupancy) return osir_pkg::ST_ABSENT;
      // close the gap left by the removed entry
      for (int i = slot; i < occupancy - 1; i++) begin
         held[i] = held[i + 1];
      end
      occupancy--;
      return osir_pkg::ST_DONE;
   endfunction

   function automatic void report(input string what, input int want_v, input int got_v);
      $error("%s mismatch: expected %0d, actual %0d", what, want_v, got_v);
      fails++;
   endfunction

   initial begin
      occupancy = 0;
      fails     = 0;
      results   = 0;
      top_count = 0;
      seen      = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         occupancy = 0;
         outcome_q.delete();
      end else begin
         // Compare a response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_status = osir_pkg::status_type'(rsp_tdata[2:0]);
            got_count  = rsp_tdata[10:3];
            if (outcome_q.size() == 0) begin
               $error("response with no request outstanding: status %0d, count %0d",
                      got_status, got_count);
               fails++;
            end else begin
               want = outcome_q.pop_front();
               if (got_status !== want.status) report("status", want.status, got_status);
               if (got_count !== want.count) report("count", want.count, got_count);
               seen[want.status] = 1'b1;
               results++;
            end
         end
         // Predict the outcome of an accepted request transaction
         if (req_tvalid && req_tready) begin
            next_status = apply_set_op(req_tuser, req_tdata);
            outcome_q.push_back('{status: next_status, count: occupancy[7:0]});
            if (occupancy > top_count) top_count = occupancy;
         end
      end
      fail_count  <= fails;
      pending     <= outcome_q.size();
      checked     <= results;
      peak        <= top_count;
      status_seen <= seen;
   end

endmodule

>>> test/ordered_set_insert_remove_core_tb.sv
// Testbench top for ordered_set_insert_remove_core: clock, reset, stimulus and verdict.
// Depends on osir_pkg, the core and ordered_set_insert_remove_checker.
`timescale 1ns / 1ps

module ordered_set_insert_remove_core_tb;

   localparam int DEPTH        = 128;
   localparam int RANDOM_ITEMS = 880;
   localparam int STALL_LIMIT  = 4000;   // must outlast the worst op and the response hold-off
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic        req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [2:0] status, [10:3] count, [15:11] zero

   int          fail_count;
   int          pending;
   int          checked;
   int          peak;
   logic [4:0]  status_seen;

   int          sent;
   int          received;

   ordered_set_insert_remove_core #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ordered_set_insert_remove_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .peak        (peak),
      .status_seen (status_seen)
   );

   always #2 clock = ~clock;

   // Spread small indexes over all 32 bits; small pools are subsets of large ones
   function automatic logic [31:0] pool_value(input int idx);
      return (idx * 32'h9E37_79B1) ^ 32'h5BD1_E995;
   endfunction

   // Offer one request transaction after a random gap and wait for acceptance
   task automatic send_item(input logic op, input logic [31:0] value);
      int gap;
      gap = ((sent / 50) % 5 == 2) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off
   initial begin : receiver
      int gap;
      rsp_tready = 1'b0;
      received   = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (received == HOLD_AT) gap = HOLD_CYCLES;
         else if ((received / 70) % 4 == 1) gap = 0;
         else gap = $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         received++;
      end
   end

   // End the run if no transaction moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int rnd;
      int len;
      int bias;
      int pool_size;
      logic op;
      logic [31:0] value;

      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = osir_pkg::OP_INSERT;
      sent       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty remove, extreme values, duplicates, removal at each position
      send_item(osir_pkg::OP_REMOVE, 32'h0000_0005);
      send_item(osir_pkg::OP_INSERT, 32'h8000_0000);
      send_item(osir_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_item(osir_pkg::OP_INSERT, 32'h0000_0000);
      send_item(osir_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_item(osir_pkg::OP_INSERT, 32'h0000_0000);
      send_item(osir_pkg::OP_INSERT, 32'h8000_0000);
      send_item(osir_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_item(osir_pkg::OP_REMOVE, 32'h1234_5678);
      send_item(osir_pkg::OP_REMOVE, 32'h7FFF_FFFF);
      send_item(osir_pkg::OP_REMOVE, 32'h8000_0000);
      send_item(osir_pkg::OP_REMOVE, 32'hFFFF_FFFF);
      send_item(osir_pkg::OP_INSERT, 32'h5555_5555);
      send_item(osir_pkg::OP_INSERT, 32'hAAAA_AAAA);
      send_item(osir_pkg::OP_REMOVE, 32'h0000_0000);
      send_item(osir_pkg::OP_REMOVE, 32'h5555_5555);
      send_item(osir_pkg::OP_REMOVE, 32'hAAAA_AAAA);
      send_item(osir_pkg::OP_REMOVE, 32'h0000_0000);
      send_item(osir_pkg::OP_INSERT, 32'h0000_0001);
      send_item(osir_pkg::OP_REMOVE, 32'h0000_0001);

      // Random bursts; the first one fills the store past capacity
      rnd       = 0;
      len       = 200;
      bias      = 95;
      pool_size = 256;
      while (rnd < RANDOM_ITEMS) begin
         for (int k = 0; k < len && rnd < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < bias) ? osir_pkg::OP_INSERT : osir_pkg::OP_REMOVE;
            if ($urandom_range(0, 9) == 0) value = $urandom();
            else value = pool_value($urandom_range(0, pool_size - 1));
            send_item(op, value);
            rnd++;
         end
         // pick the next burst: fill, drain or mixed, over a wide or narrow pool
         case ($urandom_range(0, 2))
            0: bias = 90;
            1: bias = 10;
            default: bias = 50;
         endcase
         pool_size = ($urandom_range(0, 1) == 0) ? 12 : 256;
         len       = $urandom_range(30, 150);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding responses, then allow a short tail
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d requests sent, %0d responses checked, peak occupancy %0d of %0d",
               sent, checked, peak, DEPTH);
      $display("summary: status codes seen (empty, full, absent, present, done) = %b",
               status_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
